// ===== hdl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg: shared types for the min tracking fifo
// Word formats, operation and error codes, and the cell state and control
// records passed along the chain.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_FIELD_W = 11;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] head_value;
    logic [COUNT_FIELD_W-1:0]  entry_count;
    logic signed [VALUE_W-1:0] smallest;
    logic                      is_empty;
    logic [1:0]                error_code;
  } out_word_t;

  // Contents of one cell: occupied flag, entry and minimum of it and all
  // younger entries.
  typedef struct packed {
    logic                      occ;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] min;
  } cell_state_t;

  // Broadcast to every cell in the cycle a word is taken.
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic                      clear;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hdl/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// mtf_cell: one storage cell of the min tracking fifo
// Holds one entry and the running minimum of it and every younger entry;
// takes its younger neighbor's contents on a pop.
// ----------------------------------------------------------------------------
module mtf_cell
  import mtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctrl_t  ctrl,
  input  logic        older_occ,
  input  cell_state_t younger,
  output cell_state_t state
);

  logic                      occ_r, occ_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic signed [VALUE_W-1:0] min_r, min_nxt;

  always_comb begin
    occ_nxt   = occ_r;
    value_nxt = value_r;
    min_nxt   = min_r;
    if (ctrl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctrl.pop) begin
      // shift toward the head
      occ_nxt   = younger.occ;
      value_nxt = younger.value;
      min_nxt   = younger.min;
    end else if (ctrl.push) begin
      if (occ_r) begin
        if (ctrl.value < min_r) begin
          min_nxt = ctrl.value;
        end
      end else if (older_occ) begin
        // first free cell: load the new entry
        occ_nxt   = 1'b1;
        value_nxt = ctrl.value;
        min_nxt   = ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    min_r   <= min_nxt;
  end

  assign state = '{occ: occ_r, value: value_r, min: min_r};

endmodule

// ===== hdl/min_tracking_fifo.sv =====
// ----------------------------------------------------------------------------
// min_tracking_fifo: first-in first-out queue that tracks its minimum
// Entries live in a chain of cells, oldest in cell 0; every cell keeps the
// minimum of itself and all younger cells, so cell 0 carries the queue
// minimum. Push broadcasts the value to all cells, pop shifts the chain.
// ----------------------------------------------------------------------------
// Timing: the result word is registered on the edge that takes the input
//   word. Throughput: one word per cycle while in_ready is high; the cells
//   update on that edge (broadcast compare on push, neighbor shift on pop).
// Reset (rst_n low at a clock edge): clear every cell's occupied flag, the
//   entry count and the output valid; entry payloads are not cleared and no
//   clearing pass runs, the block is ready as soon as reset is released.
module min_tracking_fifo
  import mtf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // cell_s[QUEUE_DEPTH] is an always-empty tail past the last cell
  cell_state_t cell_s [QUEUE_DEPTH+1];
  cell_ctrl_t  ctrl;

  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic in_take;
  logic empty, full;
  kind_t kind;

  logic                      head_empty;
  logic signed [VALUE_W-1:0] head_val;
  logic signed [VALUE_W-1:0] min_val;
  err_t                      err;

  // Accept a new word while the output register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  assign empty = !cell_s[0].occ;
  assign full  = cell_s[QUEUE_DEPTH-1].occ;
  assign kind  = kind_t'(in_word.kind);

  assign cell_s[QUEUE_DEPTH] = '{occ: 1'b0, value: '0, min: '0};

  // Decode the word into a chain-wide command and the post-step result.
  always_comb begin
    ctrl       = '{push: 1'b0, pop: 1'b0, clear: 1'b0, value: in_word.push_value};
    count_nxt  = count_r;
    err        = ERR_NONE;
    head_empty = empty;
    head_val   = cell_s[0].value;
    min_val    = cell_s[0].min;
    case (kind)
      KIND_PUSH: begin
        if (full) begin
          err = ERR_PUSH_FULL;
        end else begin
          ctrl.push  = in_take;
          count_nxt  = count_r + CNT_W'(1);
          head_empty = 1'b0;
          if (empty) begin
            head_val = in_word.push_value;
            min_val  = in_word.push_value;
          end else if (in_word.push_value < cell_s[0].min) begin
            min_val = in_word.push_value;
          end
        end
      end
      KIND_POP: begin
        if (empty) begin
          err = ERR_POP_EMPTY;
        end else begin
          // report the popped entry; minimum comes from the next cell
          ctrl.pop   = in_take;
          count_nxt  = count_r - CNT_W'(1);
          head_empty = !cell_s[1].occ;
          head_val   = cell_s[0].value;
          min_val    = cell_s[1].occ ? cell_s[1].min : '0;
        end
      end
      KIND_CLEAR: begin
        ctrl.clear = in_take;
        count_nxt  = '0;
        head_empty = 1'b1;
      end
      default: begin
        // query only: hold everything
      end
    endcase
  end

  always_comb begin
    out_word_nxt.head_value  = (head_empty && !(kind == KIND_POP && !empty)) ?
                               '0 : head_val;
    out_word_nxt.entry_count = COUNT_FIELD_W'(count_nxt);
    out_word_nxt.smallest    = head_empty ? '0 : min_val;
    out_word_nxt.is_empty    = head_empty;
    out_word_nxt.error_code  = err;
  end

  // Output register: load on take, drop valid once the word is consumed.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The chain: each cell sees its older neighbor's flag and younger contents.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      mtf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .older_occ(1'b1),
        .younger  (cell_s[gi+1]),
        .state    (cell_s[gi])
      );
    end else begin : g_body
      mtf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .older_occ(cell_s[gi-1].occ),
        .younger  (cell_s[gi+1]),
        .state    (cell_s[gi])
      );
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for min_tracking_fifo
// Drives push, pop, clear and query words through the valid/ready input,
// predicts every result word with a queue model of its own and checks the
// result stream field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
  import mtf_pkg::*;
();

  localparam int unsigned QDEPTH     = 1024;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 60;

  // Queue model plus the list of result words still owed by the block.
  class minq_scoreboard;
    int unsigned               depth;
    logic signed [VALUE_W-1:0] held_values[$];
    out_word_t                 pending_results[$];
    int unsigned               failures;
    int unsigned               n_checked;
    int unsigned               n_push_full;
    int unsigned               n_pop_empty;
    int unsigned               peak_fill;

    function new(int unsigned depth_in);
      depth       = depth_in;
      failures    = 0;
      n_checked   = 0;
      n_push_full = 0;
      n_pop_empty = 0;
      peak_fill   = 0;
    endfunction

    // Apply one accepted input word and queue the result it must produce.
    function void predict_step(in_word_t w);
      out_word_t                 r;
      logic signed [VALUE_W-1:0] head;
      logic signed [VALUE_W-1:0] low;
      bit                        popped;
      r      = '0;
      head   = '0;
      popped = 0;
      r.error_code = ERR_NONE;
      case (kind_t'(w.kind))
        KIND_PUSH: begin
          if (held_values.size() >= depth) begin
            r.error_code = ERR_PUSH_FULL;
            n_push_full++;
          end else begin
            held_values.push_back(w.push_value);
          end
        end
        KIND_POP: begin
          if (held_values.size() == 0) begin
            r.error_code = ERR_POP_EMPTY;
            n_pop_empty++;
          end else begin
            head   = held_values.pop_front();
            popped = 1;
          end
        end
        KIND_CLEAR: held_values.delete();
        default: ;
      endcase
      if (!popped)
        head = (held_values.size() != 0) ? held_values[0] : '0;
      low = '0;
      foreach (held_values[i])
        if (i == 0 || held_values[i] < low)
          low = held_values[i];
      if (held_values.size() > peak_fill)
        peak_fill = held_values.size();
      r.head_value  = head;
      r.entry_count = COUNT_FIELD_W'(held_values.size());
      r.smallest    = low;
      r.is_empty    = (held_values.size() == 0);
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(out_word_t got);
      out_word_t want;
      n_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: %p", $time, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.head_value !== want.head_value) begin
        $display("%0t: head_value expected %0d actual %0d", $time,
                 want.head_value, got.head_value);
        failures++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 want.entry_count, got.entry_count);
        failures++;
      end
      if (got.smallest !== want.smallest) begin
        $display("%0t: smallest expected %0d actual %0d", $time,
                 want.smallest, got.smallest);
        failures++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time,
                 want.is_empty, got.is_empty);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $display("%0t: error_code expected %0d actual %0d", $time,
                 want.error_code, got.error_code);
        failures++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  minq_scoreboard sb;
  bit             calm;        // set for the tail of the run: no idling at all
  int unsigned    queue_fill;  // sender's own view of the fill, used to steer
  int unsigned    words_sent;
  int unsigned    idle_cycles;

  min_tracking_fifo #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Snoop both handshakes at each edge. Note the input first: a result word
  // taken on the same edge always belongs to an older input word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.predict_step(in_word);
      if (out_valid && out_ready)
        sb.check_result(out_word);
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAIL min_tracking_fifo");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off once traffic is
  // flowing, so the block backs up and drops in_ready while words are offered.
  initial begin
    bit hold_done;
    hold_done = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sb.n_checked >= 40) begin
        hold_done = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Value mix: extremes, a narrow band around zero to force ties on the
  // minimum, and full-range random words.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Pick an operation by weight.
  function automatic kind_t pick_kind(int unsigned w_push, int unsigned w_pop,
                                      int unsigned w_query, int unsigned w_clear);
    int unsigned roll;
    roll = $urandom_range(0, w_push + w_pop + w_query + w_clear - 1);
    if (roll < w_push)                 return KIND_PUSH;
    if (roll < w_push + w_pop)         return KIND_POP;
    if (roll < w_push + w_pop + w_query) return KIND_QUERY;
    return KIND_CLEAR;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // after the handshake; only a random gap lowers it.
  task automatic offer_word(kind_t k, logic signed [VALUE_W-1:0] v);
    in_word_t w;
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      in_word  <= in_word_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    w.kind       = k;
    w.push_value = v;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    case (k)
      KIND_PUSH:  if (queue_fill < QDEPTH) queue_fill++;
      KIND_POP:   if (queue_fill > 0) queue_fill--;
      KIND_CLEAR: queue_fill = 0;
      default: ;
    endcase
  endtask

  // Run n words of a weighted mix with random values.
  task automatic offer_mix(int unsigned n, int unsigned w_push, int unsigned w_pop,
                           int unsigned w_query, int unsigned w_clear);
    repeat (n) offer_word(pick_kind(w_push, w_pop, w_query, w_clear), rand_value());
  endtask

  initial begin
    sb          = new(QDEPTH);
    calm        = 0;
    queue_fill  = 0;
    words_sent  = 0;
    idle_cycles = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases, extremes, ties, ignored payloads, clear.
    offer_word(KIND_QUERY, 32'sh1234_5678);
    offer_word(KIND_POP,   32'sh7FFF_FFFF);
    offer_word(KIND_PUSH,  32'sh7FFF_FFFF);
    offer_word(KIND_PUSH,  32'sh8000_0000);
    offer_word(KIND_PUSH,  32'sh0000_0000);
    offer_word(KIND_PUSH,  -32'sd1);
    offer_word(KIND_QUERY, -32'sd1);
    offer_word(KIND_POP,   32'sh5555_5555);
    offer_word(KIND_POP,   32'shAAAA_AAAA);
    offer_word(KIND_PUSH,  32'sd5);
    offer_word(KIND_PUSH,  32'sd5);
    offer_word(KIND_PUSH,  32'sh8000_0000);
    offer_word(KIND_CLEAR, 32'sh8000_0000);
    offer_word(KIND_POP,   32'sd0);
    offer_word(KIND_CLEAR, -32'sd1);
    offer_word(KIND_PUSH,  32'sd1);
    offer_word(KIND_PUSH,  32'shAAAA_AAAA);
    offer_word(KIND_PUSH,  32'sh5555_5555);
    offer_word(KIND_POP,   32'sd0);
    offer_word(KIND_POP,   32'sd0);
    offer_word(KIND_POP,   32'sd0);
    offer_word(KIND_POP,   32'sd0);

    // Random: short shallow mix, then climb to full, hammer the full queue,
    // drain part of it, and finish with a calm mix after a clear.
    offer_mix(50, 45, 35, 12, 8);
    while (queue_fill < QDEPTH)
      offer_word(pick_kind(95, 2, 3, 0), rand_value());
    offer_mix(6, 80, 0, 20, 0);
    offer_word(KIND_POP, rand_value());
    offer_word(KIND_PUSH, 32'sh8000_0000);
    offer_mix(4, 90, 0, 10, 0);
    offer_mix(40, 10, 85, 5, 0);
    offer_word(KIND_CLEAR, rand_value());
    calm = 1;
    offer_mix(40, 45, 35, 12, 8);

    // Drain: drop valid, wait for every owed result, then keep watching the
    // quiet channels to catch anything extra.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d words, checked %0d results, peak fill %0d of %0d.",
             words_sent, sb.n_checked, sb.peak_fill, QDEPTH);
    $display("Pushes on full: %0d, pops on empty: %0d, failures: %0d.",
             sb.n_push_full, sb.n_pop_empty, sb.failures);
    if (sb.failures == 0 && sb.pending_results.size() == 0)
      $display("PASS min_tracking_fifo");
    else
      $display("FAIL min_tracking_fifo");
    $finish;
  end

endmodule
